[hw/rtl/rcir_pkg.sv]
// Shared types and constants for the range-compressed index rank block.
`default_nettype none

package rcir_pkg;

	// Fixed field widths of the transaction payloads
	localparam int KEY_W   = 32;
	localparam int RANK_W  = 32;
	localparam int TOTAL_W = 33;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ORDER = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] index;
	} cmd_t;

	typedef struct packed {
		logic              found;
		logic [RANK_W-1:0] position;
		status_t           status;
	} res_t;

endpackage

`default_nettype wire

[hw/rtl/rcir_cell.sv]
// One search cell: holds the ranges of one bisection level and decides one result bit.
`default_nettype none

module rcir_cell #(
	parameter int LEVEL = 0,
	parameter int LW    = 9,
	parameter int IW    = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// token from the previous cell
	input  wire logic                             in_valid,
	input  wire logic [LW-1:0]                    in_pos,
	input  wire logic                             in_hit,
	input  wire logic [2*IW+rcir_pkg::RANK_W:0]   in_entry,
	// shared lookup operands
	input  wire logic [IW-1:0]                    key,
	input  wire logic [LW-1:0]                    count,
	// range store write port
	input  wire logic                             wr_en,
	input  wire logic [LW-1:0]                    wr_idx,
	input  wire logic [2*IW+rcir_pkg::RANK_W:0]   wr_entry,
	// token to the next cell
	output logic                                  out_valid,
	output logic [LW-1:0]                         out_pos,
	output logic                                  out_hit,
	output logic [2*IW+rcir_pkg::RANK_W:0]        out_entry
);
	import rcir_pkg::*;

	localparam int EW    = 2*IW + 1 + RANK_W;
	// this level owns the range numbers whose low LEVEL+1 bits are 0 then all ones
	localparam int AW    = (LW-1-LEVEL > 0) ? (LW-1-LEVEL) : 1;
	localparam int DEPTH = 2**AW;
	localparam logic [LW-1:0] LOW_MASK = LW'((2**(LEVEL+1)) - 1);
	localparam logic [LW-1:0] PAT      = LW'((2**LEVEL) - 1);
	localparam logic [LW-1:0] STEP     = LW'(2**LEVEL);

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;
	logic          v_q;
	logic [LW-1:0] pos_q;
	logic          hit_q;
	logic [EW-1:0] entry_q;

	logic [LW-1:0] probe;
	logic [IW-1:0] rd_start;
	logic          take;

	// range store slice: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en && ((wr_idx & LOW_MASK) == PAT)) begin
			mem[AW'(wr_idx >> (LEVEL+1))] <= wr_entry;
		end
		rd_q <= mem[AW'(in_pos >> (LEVEL+1))];
	end

	// token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= in_pos;
		hit_q   <= in_hit;
		entry_q <= in_entry;
	end

	// step: move past the probed range when it is in use and starts at or below the key
	assign probe    = pos_q | PAT;
	assign rd_start = rd_q[EW-1 -: IW];
	assign take     = v_q && (probe < count) && (rd_start <= key);

	assign out_valid = v_q;
	assign out_pos   = take ? (pos_q | STEP) : pos_q;
	assign out_hit   = hit_q | take;
	assign out_entry = take ? rd_q : entry_q;

endmodule

`default_nettype wire

[hw/rtl/range_compressed_index_rank.sv]
// Top level of the range-compressed index rank block.
`default_nettype none

// Keeps a set of indices as sorted half-open ranges and answers rank lookups.
// Inserts must arrive in strictly increasing order: an index at the end of the
// last range extends it, a larger one opens a new range, anything else is
// refused with status 1, and a new range with the store full gives status 2.
// Each transaction in gives exactly one transaction out; one is worked on at a
// time, and a new one is taken while the previous result still waits.
// Insert, clear and unused codes are done in S_EXEC. A lookup passes S_EXEC,
// S_SEARCH and S_RESOLVE and walks a chain of LW = clog2(MAX_RANGES + 1) cells
// (9 at the default of 256), one bisection level per cell, each owning the
// ranges probed at its level and doing one registered read per lookup. No
// clearing pass is needed.
module range_compressed_index_rank #(
	parameter int MAX_RANGES  = 256,
	parameter int INDEX_WIDTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire rcir_pkg::cmd_t cmd,
	output logic                res_valid,
	input  wire logic           res_stall,
	output rcir_pkg::res_t      res
);
	import rcir_pkg::*;

	localparam int IW = INDEX_WIDTH;
	localparam int LW = $clog2(MAX_RANGES + 1);
	localparam int EW = 2*IW + 1 + RANK_W;
	localparam logic [LW-1:0]      MAXC     = LW'(MAX_RANGES);
	localparam logic [LW-1:0]      CNT_ONE  = LW'(1);
	localparam logic [IW:0]        KEY_ONE  = (IW+1)'(1);
	localparam logic [TOTAL_W-1:0] TOT_ONE  = TOTAL_W'(1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SEARCH,
		S_RESOLVE
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [IW-1:0]       key_q;
	logic [LW-1:0]       count_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [IW-1:0]       last_start_q;
	logic [IW:0]         last_stop_q;
	logic [RANK_W-1:0]   last_before_q;
	logic                found_q;
	logic [RANK_W-1:0]   before_q;
	logic [RANK_W-1:0]   diff_q;
	logic                res_valid_q;
	res_t                res_q;

	logic                out_free;
	logic                res_load;
	logic [IW:0]         key_ext;
	logic                has_last;
	logic                below;
	logic                extend;
	logic                full;
	status_t             ins_status;
	logic                do_exec;
	logic                wr_en;
	logic [LW-1:0]       wr_idx;
	logic [EW-1:0]       wr_entry;
	logic                launch;

	// chain of search cells, stage 0 feeds the top level
	logic                ch_valid [LW+1];
	logic [LW-1:0]       ch_pos   [LW+1];
	logic                ch_hit   [LW+1];
	logic [EW-1:0]       ch_entry [LW+1];

	logic [IW-1:0]       hit_start;
	logic [IW:0]         hit_stop;
	logic [RANK_W-1:0]   hit_before;

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign out_free  = !res_valid_q || !res_stall;
	assign res_load  = out_free && (((state_q == S_EXEC) && (op_q != OP_LOOKUP)) ||
	                                (state_q == S_RESOLVE));

	// insert decode against the last range
	assign key_ext  = {1'b0, key_q};
	assign has_last = (count_q != '0);
	assign below    = has_last && (key_ext < last_stop_q);
	assign extend   = has_last && (key_ext == last_stop_q);
	assign full     = (count_q == MAXC);

	always_comb begin
		if (below) begin
			ins_status = ST_ORDER;
		end else if (!extend && full) begin
			ins_status = ST_FULL;
		end else begin
			ins_status = ST_OK;
		end
	end

	assign do_exec  = (state_q == S_EXEC) && out_free;
	assign wr_en    = do_exec && (op_q == OP_INSERT) && !below && (extend || !full);
	assign wr_idx   = extend ? (count_q - CNT_ONE) : count_q;
	assign wr_entry = extend ? {last_start_q, last_stop_q + KEY_ONE, last_before_q}
	                         : {key_q, key_ext + KEY_ONE, total_q[RANK_W-1:0]};
	assign launch   = (state_q == S_EXEC) && (op_q == OP_LOOKUP);

	assign ch_valid[0] = launch;
	assign ch_pos[0]   = '0;
	assign ch_hit[0]   = 1'b0;
	assign ch_entry[0] = '0;

	for (genvar g = 0; g < LW; g++) begin : g_cell
		rcir_cell #(
			.LEVEL (LW-1-g),
			.LW    (LW),
			.IW    (IW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (ch_valid[g]),
			.in_pos    (ch_pos[g]),
			.in_hit    (ch_hit[g]),
			.in_entry  (ch_entry[g]),
			.key       (key_q),
			.count     (count_q),
			.wr_en     (wr_en),
			.wr_idx    (wr_idx),
			.wr_entry  (wr_entry),
			.out_valid (ch_valid[g+1]),
			.out_pos   (ch_pos[g+1]),
			.out_hit   (ch_hit[g+1]),
			.out_entry (ch_entry[g+1])
		);
	end

	// range picked by the search: last one starting at or below the key
	assign hit_start  = ch_entry[LW][EW-1 -: IW];
	assign hit_stop   = ch_entry[LW][IW+RANK_W -: IW+1];
	assign hit_before = ch_entry[LW][RANK_W-1:0];

	// sequencer, set bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// result flag: raised on a load, dropped once taken
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q    <= cmd.op;
						key_q   <= IW'(cmd.index);
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q == OP_LOOKUP) begin
						state_q <= S_SEARCH;
					end else if (out_free) begin
						res_q.found     <= 1'b0;
						res_q.position  <= '0;
						state_q         <= S_IDLE;
						case (op_q)
							OP_INSERT: begin
								res_q.status <= ins_status;
								if (wr_en) begin
									total_q <= total_q + TOT_ONE;
									if (extend) begin
										last_stop_q <= last_stop_q + KEY_ONE;
									end else begin
										last_start_q  <= key_q;
										last_stop_q   <= key_ext + KEY_ONE;
										last_before_q <= total_q[RANK_W-1:0];
										count_q       <= count_q + CNT_ONE;
									end
								end
							end
							OP_CLEAR: begin
								res_q.status <= ST_OK;
								count_q      <= '0;
								total_q      <= '0;
							end
							default: begin
								res_q.status <= ST_OK;
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (ch_valid[LW]) begin
						found_q  <= ch_hit[LW] && (key_ext < hit_stop);
						before_q <= hit_before;
						diff_q   <= RANK_W'(key_q - hit_start);
						state_q  <= S_RESOLVE;
					end
				end
				S_RESOLVE: begin
					if (out_free) begin
						res_q.found    <= found_q;
						res_q.position <= found_q ? (before_q + diff_q) : '0;
						res_q.status   <= ST_OK;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
